### src/bms_pkg.sv
package bms_pkg;

	// Field and register widths.
	localparam int CMD_W    = 2;
	localparam int SAMPLE_W = 10;
	localparam int MV_W     = 13;
	localparam int WORD_W   = 16;
	localparam int SCALED_W = 23;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int INTERVAL_W = 8;
	localparam int SEC_W   = 6;
	localparam int STEP_W  = 5;
	localparam int MODE_W  = 2;
	localparam int PHASE_W = 2;
	localparam int FILL_W  = 2;

	// Event codes.
	localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNPARK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DONE   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_INTERVAL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRECHECK_HIGH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRECHECK_LOW     = 2'd3;

	// Scheduler modes. The unused code is never entered and behaves as parked.
	localparam logic [MODE_W-1:0] MODE_COUNTING = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PARKED   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOADSEQ  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

	// Precheck modes.
	localparam logic PRE_COUNTING = 1'b0;
	localparam logic PRE_PARKED   = 1'b1;

	// Conversion phases.
	localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
	localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;
	localparam logic [PHASE_W-1:0] PH_FINAL  = 2'd3;

	// Voltage constants in millivolts.
	localparam logic [MV_W-1:0] MV_START     = 13'd3000;
	localparam logic [MV_W-1:0] MV_RISE_HIGH = 13'd2900;
	localparam logic [MV_W-1:0] MV_RISE_LOW  = 13'd2500;
	localparam logic [MV_W-1:0] MV_MAX       = 13'd8191;
	localparam logic [MV_W-1:0] PRE_HIGH_RESET = 13'd2500;
	localparam logic [MV_W-1:0] PRE_LOW_RESET  = 13'd1800;

	// Pulse pattern steps with both switches on.
	localparam logic [STEP_W-1:0] PULSE_ON_A = 5'd0;
	localparam logic [STEP_W-1:0] PULSE_ON_B = 5'd11;
	localparam logic [STEP_W-1:0] PULSE_ON_C = 5'd22;

	// Converter scaling: mv = floor((7914 * sample - 174100) / 1000).
	localparam logic [MV_W-1:0] MV_GAIN = 13'd7914;
	localparam logic [SCALED_W-1:0] MV_OFFSET = 23'd174100;
	// Division by 1000 as a multiply by ceil(2^33 / 1000); exact for inputs below 2^23.
	localparam int RECIP_SHIFT = 33;
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589935;
	localparam int PROD_W = SCALED_W + RECIP_W;
	localparam int QUOT_W = PROD_W - RECIP_SHIFT;

	typedef struct packed {
		logic [INTERVAL_W-1:0] measure_interval;
		logic [INTERVAL_W-1:0] load_interval;
		logic [MV_W-1:0]       pre_high;
		logic [MV_W-1:0]       pre_low;
	} cfg_t;

	// Item held in the input register: event plus the scaled sample.
	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic                neg;
		logic [SCALED_W-1:0] scaled;
	} item_t;

	typedef struct packed {
		logic              on_pin;
		logic              load_pin;
		logic              start_conversion;
		logic              report_valid;
		logic [WORD_W-1:0] report_word;
		logic              precheck_active;
	} result_t;

	// First step of the conversion: gain and offset.
	function automatic item_t scale_item(input logic [CMD_W-1:0] command,
			input logic [SAMPLE_W-1:0] sample);
		logic [SCALED_W-1:0] prod;
		item_t it;
		prod = SCALED_W'(sample) * SCALED_W'(MV_GAIN);
		it.command = command;
		it.neg     = (prod < MV_OFFSET);
		it.scaled  = it.neg ? '0 : (prod - MV_OFFSET);
		return it;
	endfunction

	// Second step: divide by 1000 and saturate.
	function automatic logic [MV_W-1:0] to_mv(input logic neg,
			input logic [SCALED_W-1:0] scaled);
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] quot;
		prod = PROD_W'(scaled) * PROD_W'(RECIP_1000);
		quot = prod[PROD_W-1:RECIP_SHIFT];
		if (neg) begin
			return '0;
		end else if (quot > QUOT_W'(MV_MAX)) begin
			return MV_MAX;
		end
		return quot[MV_W-1:0];
	endfunction

endpackage

### src/bms_if.sv
// Event channel into the sequencer.
interface bms_in_if;
	logic                          valid;
	logic                          ready;
	logic [bms_pkg::CMD_W-1:0]     command;
	logic [bms_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink (input valid, input command, input sample, output ready);
endinterface

// Result channel out of the sequencer.
interface bms_out_if;
	logic                        valid;
	logic                        ready;
	logic                        on_pin;
	logic                        load_pin;
	logic                        start_conversion;
	logic                        report_valid;
	logic [bms_pkg::WORD_W-1:0]  report_word;
	logic                        precheck_active;

	modport source (output valid, output on_pin, output load_pin, output start_conversion,
		output report_valid, output report_word, output precheck_active, input ready);
	modport sink (input valid, input on_pin, input load_pin, input start_conversion,
		input report_valid, input report_word, input precheck_active, output ready);
endinterface

// Configuration write channel.
interface bms_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bms_pkg::CFG_IDX_W-1:0]   index;
	logic [bms_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/bms_core.sv
module bms_core #(
	parameter int TICKS_PER_MINUTE = 60,
	parameter int PULSE_LAST_STEP = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bms_pkg::item_t   item,
	input  bms_pkg::cfg_t    cfg,
	output bms_pkg::result_t result
);
	import bms_pkg::*;

	logic [MODE_W-1:0]     sched_mode_q, sched_mode_n;
	logic [PHASE_W-1:0]    conv_phase_q, conv_phase_n;
	logic                  pre_mode_q, pre_mode_n;
	logic                  pre_waiting_q, pre_waiting_n;
	logic                  precheck_q, precheck_n;
	logic [INTERVAL_W-1:0] tick_q, tick_n;
	logic [SEC_W-1:0]      sec_q, sec_n;
	logic [INTERVAL_W-1:0] min_q, min_n;
	logic [STEP_W-1:0]     step_q, step_n;
	logic [MV_W-1:0]       old_mv_q, old_mv_n;
	logic [MV_W-1:0]       new_mv_q, new_mv_n;
	logic [MV_W-1:0]       win_q [3];
	logic [MV_W-1:0]       win_n [3];
	logic [FILL_W-1:0]     fill_q, fill_n;
	logic                  loaded_q, loaded_n;
	logic                  on_q, on_n;
	logic                  load_q, load_n;

	logic [INTERVAL_W-1:0] cnt_tick;
	logic [SEC_W-1:0]      cnt_sec;
	logic [INTERVAL_W-1:0] cnt_min;
	logic                  cnt_due;
	logic                  cnt_loaded;
	logic [MV_W-1:0]       mv;
	logic                  start;
	logic                  report;
	logic                  pulse_on;

	// Scheduler counters as they would stand after one more tick.
	always_comb begin
		cnt_tick = tick_q;
		cnt_sec  = sec_q;
		cnt_min  = min_q;
		if (tick_q < cfg.measure_interval) begin
			cnt_tick = tick_q + 1'b1;
		end
		if (min_q < cfg.load_interval) begin
			cnt_sec = sec_q + 1'b1;
			if (32'(cnt_sec) >= 32'(TICKS_PER_MINUTE)) begin
				cnt_sec = '0;
				cnt_min = min_q + 1'b1;
			end
		end
		cnt_due    = (cnt_tick >= cfg.measure_interval);
		cnt_loaded = (cnt_min >= cfg.load_interval);
	end

	assign mv = to_mv(item.neg, item.scaled);
	assign pulse_on = (step_q == PULSE_ON_A) || (step_q == PULSE_ON_B) ||
		(step_q == PULSE_ON_C);

	// Event handling: next state and the result of the current word.
	always_comb begin
		sched_mode_n  = sched_mode_q;
		conv_phase_n  = conv_phase_q;
		pre_mode_n    = pre_mode_q;
		pre_waiting_n = pre_waiting_q;
		precheck_n    = precheck_q;
		tick_n   = tick_q;
		sec_n    = sec_q;
		min_n    = min_q;
		step_n   = step_q;
		old_mv_n = old_mv_q;
		new_mv_n = new_mv_q;
		win_n    = win_q;
		fill_n   = fill_q;
		loaded_n = loaded_q;
		on_n     = on_q;
		load_n   = load_q;
		start    = 1'b0;
		report   = 1'b0;

		if (item.command == CMD_INIT) begin
			sched_mode_n = MODE_COUNTING;
			step_n   = '0;
			old_mv_n = MV_START;
			new_mv_n = MV_START;
			if (precheck_q) begin
				fill_n = '0;
				win_n  = '{default: '0};
				pre_mode_n = PRE_COUNTING;
			end
		end else if (precheck_q) begin
			// Precheck phase: one measurement per tick, windowed decision.
			unique case (item.command)
				CMD_TICK: begin
					if (pre_mode_q == PRE_COUNTING) begin
						on_n = 1'b1;
						loaded_n = 1'b0;
						old_mv_n = new_mv_q;
						pre_waiting_n = 1'b1;
						start = 1'b1;
					end
				end
				CMD_UNPARK: begin
					pre_mode_n = PRE_COUNTING;
					pre_waiting_n = 1'b0;
				end
				default: begin
					if (pre_waiting_q) begin
						on_n = 1'b0;
						load_n = 1'b0;
						new_mv_n = mv;
						win_n[0] = win_q[1];
						win_n[1] = win_q[2];
						win_n[2] = mv;
						if (fill_q < 2'd3) begin
							fill_n = fill_q + 1'b1;
						end
						if (fill_n == 2'd3) begin
							if ((win_n[0] > cfg.pre_high) && (win_n[1] > cfg.pre_high) &&
									(win_n[2] > cfg.pre_high)) begin
								precheck_n = 1'b0;
							end
							if ((win_n[0] < cfg.pre_low) && (win_n[1] < cfg.pre_low) &&
									(win_n[2] < cfg.pre_low)) begin
								precheck_n = 1'b0;
							end
						end
						pre_mode_n = PRE_COUNTING;
						pre_waiting_n = 1'b0;
					end
				end
			endcase
		end else begin
			unique case (item.command)
				CMD_TICK: begin
					if (sched_mode_q == MODE_COUNTING) begin
						// Scheduled measurement, light or loaded.
						if (cfg.measure_interval != '0) begin
							tick_n = cnt_tick;
							sec_n  = cnt_sec;
							min_n  = cnt_min;
							if (cnt_due) begin
								on_n = 1'b1;
								old_mv_n = new_mv_q;
								start = 1'b1;
								tick_n = '0;
								sched_mode_n = MODE_PARKED;
								if (cnt_loaded) begin
									load_n = 1'b1;
									loaded_n = 1'b1;
									conv_phase_n = PH_FIRST;
									sec_n = '0;
									min_n = '0;
								end else begin
									loaded_n = 1'b0;
									conv_phase_n = PH_SECOND;
								end
							end
						end
					end else if (sched_mode_q == MODE_LOADSEQ) begin
						// Load pulse pattern, one step per tick.
						on_n = pulse_on;
						load_n = pulse_on;
						if (32'(step_q) == 32'(PULSE_LAST_STEP)) begin
							step_n = '0;
							sched_mode_n = MODE_COUNTING;
						end else begin
							step_n = step_q + 1'b1;
						end
					end else begin
						if (cfg.measure_interval != '0) begin
							tick_n = cnt_tick;
							sec_n  = cnt_sec;
							min_n  = cnt_min;
						end
					end
				end
				CMD_UNPARK: begin
					if ((sched_mode_q == MODE_PARKED) || (sched_mode_q == MODE_UNUSED)) begin
						sched_mode_n = MODE_COUNTING;
					end
					conv_phase_n = PH_IDLE;
				end
				default: begin
					if ((conv_phase_q == PH_FIRST) || (conv_phase_q == PH_SECOND)) begin
						new_mv_n = mv;
						conv_phase_n = PH_FINAL;
						start = 1'b1;
					end else if (conv_phase_q == PH_FINAL) begin
						on_n = 1'b0;
						load_n = 1'b0;
						new_mv_n = mv;
						conv_phase_n = PH_IDLE;
						report = 1'b1;
						if ((mv > MV_RISE_HIGH) && (old_mv_q < MV_RISE_LOW)) begin
							step_n = '0;
							sched_mode_n = MODE_LOADSEQ;
						end
					end
				end
			endcase
		end
	end

	// Result of the word being processed.
	always_comb begin
		result.on_pin = on_n;
		result.load_pin = load_n;
		result.start_conversion = start;
		result.report_valid = report;
		result.report_word = report ? {loaded_q, 2'b00, mv} : '0;
		result.precheck_active = precheck_n;
	end

	// State registers; they move only when a word is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_mode_q  <= MODE_PARKED;
			conv_phase_q  <= PH_IDLE;
			pre_mode_q    <= PRE_PARKED;
			pre_waiting_q <= 1'b0;
			precheck_q    <= 1'b1;
			tick_q   <= '0;
			sec_q    <= '0;
			min_q    <= '0;
			step_q   <= '0;
			old_mv_q <= MV_START;
			new_mv_q <= MV_START;
			win_q    <= '{default: '0};
			fill_q   <= '0;
			loaded_q <= 1'b0;
			on_q     <= 1'b0;
			load_q   <= 1'b0;
		end else if (en) begin
			sched_mode_q  <= sched_mode_n;
			conv_phase_q  <= conv_phase_n;
			pre_mode_q    <= pre_mode_n;
			pre_waiting_q <= pre_waiting_n;
			precheck_q    <= precheck_n;
			tick_q   <= tick_n;
			sec_q    <= sec_n;
			min_q    <= min_n;
			step_q   <= step_n;
			old_mv_q <= old_mv_n;
			new_mv_q <= new_mv_n;
			win_q    <= win_n;
			fill_q   <= fill_n;
			loaded_q <= loaded_n;
			on_q     <= on_n;
			load_q   <= load_n;
		end
	end

endmodule

### src/battery_measure_sequencer.sv
// Two register stages: the input register holds an event word and the result register
// holds its result word.
// Throughput: one event word per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result word is not taken.
// The sample gain multiply sits in front of the input register and the divide by 1000
// and state update in front of the result register.
// Reset puts sequencer state in its start values and configuration registers in defaults.
module battery_measure_sequencer #(
	parameter int TICKS_PER_MINUTE = 60,
	parameter int PULSE_LAST_STEP = 23
) (
	input logic        clk,
	input logic        arst_n,
	bms_in_if.sink     event_ch,
	bms_out_if.source  result_ch,
	bms_cfg_if.sink    cfg
);
	import bms_pkg::*;

	logic    item_valid_s1;
	item_t   item_s1;
	logic    res_valid_s2;
	result_t res_s2;
	result_t res;
	cfg_t    cfg_q;
	logic    advance;

	// The pipeline moves whenever the result register is free or being emptied.
	assign advance = !res_valid_s2 || result_ch.ready;
	assign event_ch.ready = !item_valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.measure_interval <= '0;
			cfg_q.load_interval <= '0;
			cfg_q.pre_high <= PRE_HIGH_RESET;
			cfg_q.pre_low <= PRE_LOW_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MEASURE_INTERVAL: cfg_q.measure_interval <= cfg.data[INTERVAL_W-1:0];
				REG_LOAD_INTERVAL:    cfg_q.load_interval <= cfg.data[INTERVAL_W-1:0];
				REG_PRECHECK_HIGH:    cfg_q.pre_high <= cfg.data[MV_W-1:0];
				REG_PRECHECK_LOW:     cfg_q.pre_low <= cfg.data[MV_W-1:0];
			endcase
		end
	end

	// Input register with the scaled sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (event_ch.ready) begin
			item_valid_s1 <= event_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ch.ready && event_ch.valid) begin
			item_s1 <= scale_item(event_ch.command, event_ch.sample);
		end
	end

	bms_core #(
		.TICKS_PER_MINUTE(TICKS_PER_MINUTE),
		.PULSE_LAST_STEP(PULSE_LAST_STEP)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(item_valid_s1 && advance),
		.item(item_s1),
		.cfg(cfg_q),
		.result(res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1) begin
			res_s2 <= res;
		end
	end

	assign result_ch.valid = res_valid_s2;
	assign result_ch.on_pin = res_s2.on_pin;
	assign result_ch.load_pin = res_s2.load_pin;
	assign result_ch.start_conversion = res_s2.start_conversion;
	assign result_ch.report_valid = res_s2.report_valid;
	assign result_ch.report_word = res_s2.report_word;
	assign result_ch.precheck_active = res_s2.precheck_active;

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bms_pkg::*;

	localparam int MINUTE_TICKS = 60;
	localparam int LAST_PULSE_STEP = 23;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_REPORTS = 40;
	localparam int MV_DIVISOR = 1000;
	localparam logic [WORD_W-1:0] LOADED_BIT = 16'h8000;

	typedef enum {MEAS_NONE, MEAS_LIGHT, MEAS_LOADED} meas_kind_t;

	// Tracks the sequencer state and keeps the expected result word per event word.
	class sequencer_scoreboard;
		logic [INTERVAL_W-1:0] meas_ivl;
		logic [INTERVAL_W-1:0] load_ivl;
		logic [MV_W-1:0] pre_high;
		logic [MV_W-1:0] pre_low;
		logic [MODE_W-1:0] mode;
		logic [PHASE_W-1:0] phase;
		logic pre_mode;
		logic pre_wait;
		logic pre_flag;
		logic [INTERVAL_W-1:0] ticks;
		logic [SEC_W-1:0] secs;
		logic [INTERVAL_W-1:0] mins;
		logic [STEP_W-1:0] step;
		logic [MV_W-1:0] old_mv;
		logic [MV_W-1:0] new_mv;
		logic [MV_W-1:0] window [3];
		logic [FILL_W-1:0] fill;
		logic loaded;
		logic on_lvl;
		logic load_lvl;
		result_t expected_results[$];
		int mismatches;

		function new();
			meas_ivl = '0;
			load_ivl = '0;
			pre_high = PRE_HIGH_RESET;
			pre_low = PRE_LOW_RESET;
			mode = MODE_PARKED;
			phase = PH_IDLE;
			pre_mode = PRE_PARKED;
			pre_wait = 1'b0;
			pre_flag = 1'b1;
			ticks = '0;
			secs = '0;
			mins = '0;
			step = '0;
			old_mv = MV_START;
			new_mv = MV_START;
			foreach (window[i]) window[i] = '0;
			fill = '0;
			loaded = 1'b0;
			on_lvl = 1'b0;
			load_lvl = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MEASURE_INTERVAL: meas_ivl = data[INTERVAL_W-1:0];
				REG_LOAD_INTERVAL: load_ivl = data[INTERVAL_W-1:0];
				REG_PRECHECK_HIGH: pre_high = data[MV_W-1:0];
				REG_PRECHECK_LOW: pre_low = data[MV_W-1:0];
			endcase
		endfunction

		// Exact integer millivolts, clamped at both ends.
		function logic [MV_W-1:0] sample_to_mv(logic [SAMPLE_W-1:0] smp);
			int scaled;
			scaled = int'(smp) * int'(MV_GAIN) - int'(MV_OFFSET);
			if (scaled < 0) begin
				return '0;
			end
			scaled = scaled / MV_DIVISOR;
			if (scaled > int'(MV_MAX)) begin
				return MV_MAX;
			end
			return scaled[MV_W-1:0];
		endfunction

		// Advances the tick and minute counters and tells which measurement is due.
		function meas_kind_t advance_counters();
			if (ticks < meas_ivl) ticks++;
			if (mins < load_ivl) begin
				secs = secs + 1'b1;
				if (secs >= MINUTE_TICKS) begin
					secs = '0;
					mins++;
				end
			end
			if (ticks >= meas_ivl) begin
				return (mins >= load_ivl) ? MEAS_LOADED : MEAS_LIGHT;
			end
			return MEAS_NONE;
		endfunction

		function result_t predict_result(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp);
			result_t r;
			logic start_p;
			logic valid_p;
			logic [WORD_W-1:0] word;
			logic pulse_on;
			meas_kind_t kind;
			start_p = 1'b0;
			valid_p = 1'b0;
			word = '0;
			if (cmd == CMD_INIT) begin
				mode = MODE_COUNTING;
				step = '0;
				old_mv = MV_START;
				new_mv = MV_START;
				if (pre_flag) begin
					fill = '0;
					foreach (window[i]) window[i] = '0;
					pre_mode = PRE_COUNTING;
				end
			end else if (pre_flag) begin
				// Precheck owns every event but init; the scheduler stays frozen.
				if (cmd == CMD_TICK) begin
					if (pre_mode == PRE_COUNTING) begin
						on_lvl = 1'b1;
						loaded = 1'b0;
						old_mv = new_mv;
						pre_wait = 1'b1;
						start_p = 1'b1;
					end
				end else if (cmd == CMD_UNPARK) begin
					pre_mode = PRE_COUNTING;
					pre_wait = 1'b0;
				end else if (pre_wait) begin
					on_lvl = 1'b0;
					load_lvl = 1'b0;
					new_mv = sample_to_mv(smp);
					window[0] = window[1];
					window[1] = window[2];
					window[2] = new_mv;
					if (fill < 3) fill++;
					if (fill >= 3) begin
						if (window[0] > pre_high && window[1] > pre_high && window[2] > pre_high)
							pre_flag = 1'b0;
						if (window[0] < pre_low && window[1] < pre_low && window[2] < pre_low)
							pre_flag = 1'b0;
					end
					pre_mode = PRE_COUNTING;
					pre_wait = 1'b0;
				end
			end else if (cmd == CMD_TICK) begin
				if (mode == MODE_COUNTING) begin
					if (meas_ivl != 0) begin
						kind = advance_counters();
						if (kind == MEAS_LIGHT) begin
							on_lvl = 1'b1;
							loaded = 1'b0;
							old_mv = new_mv;
							phase = PH_SECOND;
							start_p = 1'b1;
							ticks = '0;
						end else if (kind == MEAS_LOADED) begin
							on_lvl = 1'b1;
							load_lvl = 1'b1;
							loaded = 1'b1;
							old_mv = new_mv;
							phase = PH_FIRST;
							start_p = 1'b1;
							ticks = '0;
							secs = '0;
							mins = '0;
						end
						if (kind != MEAS_NONE) mode = MODE_PARKED;
					end
				end else if (mode == MODE_LOADSEQ) begin
					// Pulse pattern: both switches on at three fixed steps.
					pulse_on = (step == PULSE_ON_A || step == PULSE_ON_B || step == PULSE_ON_C);
					on_lvl = pulse_on;
					load_lvl = pulse_on;
					if (step == LAST_PULSE_STEP) begin
						step = '0;
						mode = MODE_COUNTING;
					end else begin
						step = step + 1'b1;
					end
				end else if (meas_ivl != 0) begin
					void'(advance_counters());
				end
			end else if (cmd == CMD_UNPARK) begin
				if (mode != MODE_COUNTING && mode != MODE_LOADSEQ) mode = MODE_COUNTING;
				phase = PH_IDLE;
			end else begin
				if (phase == PH_FIRST || phase == PH_SECOND) begin
					new_mv = sample_to_mv(smp);
					phase = PH_FINAL;
					start_p = 1'b1;
				end else if (phase == PH_FINAL) begin
					on_lvl = 1'b0;
					load_lvl = 1'b0;
					new_mv = sample_to_mv(smp);
					phase = PH_IDLE;
					valid_p = 1'b1;
					word = WORD_W'(new_mv) | (loaded ? LOADED_BIT : '0);
					// A recovery from a weak battery starts the load pulse pattern.
					if (new_mv > MV_RISE_HIGH && old_mv < MV_RISE_LOW) begin
						step = '0;
						mode = MODE_LOADSEQ;
					end
				end
			end
			r.on_pin = on_lvl;
			r.load_pin = load_lvl;
			r.start_conversion = start_p;
			r.report_valid = valid_p;
			r.report_word = word;
			r.precheck_active = pre_flag;
			return r;
		endfunction

		function void note_event(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp);
			expected_results.push_back(predict_result(cmd, smp));
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result word with no event pending", int'(got), 0);
				return;
			end
			want = expected_results.pop_front();
			if (got.on_pin !== want.on_pin)
				report_mismatch("on_pin", got.on_pin, want.on_pin);
			if (got.load_pin !== want.load_pin)
				report_mismatch("load_pin", got.load_pin, want.load_pin);
			if (got.start_conversion !== want.start_conversion)
				report_mismatch("start_conversion", got.start_conversion, want.start_conversion);
			if (got.report_valid !== want.report_valid)
				report_mismatch("report_valid", got.report_valid, want.report_valid);
			if (got.report_word !== want.report_word)
				report_mismatch("report_word", got.report_word, want.report_word);
			if (got.precheck_active !== want.precheck_active)
				report_mismatch("precheck_active", got.precheck_active, want.precheck_active);
		endtask
	endclass

	logic clk;
	logic arst_n;
	int tx_idle_pct;
	int rx_stall_pct;
	int hold_requests;
	int quiet_cycles;
	sequencer_scoreboard sb = new();

	bms_in_if in_ch();
	bms_out_if out_ch();
	bms_cfg_if cfg_ch();

	battery_measure_sequencer #(
		.TICKS_PER_MINUTE(MINUTE_TICKS),
		.PULSE_LAST_STEP(LAST_PULSE_STEP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.event_ch(in_ch),
		.result_ch(out_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stalls, plus one long hold-off when asked.
	initial begin : receiver
		int held;
		int seen;
		held = 0;
		seen = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen) begin
				seen = hold_requests;
				held = HOLD_CYCLES;
			end
			if (held > 0) begin
				held--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Every accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_result(result_t'{out_ch.on_pin, out_ch.load_pin, out_ch.start_conversion,
				out_ch.report_valid, out_ch.report_word, out_ch.precheck_active});
	end

	// Ends the run when no channel has moved a word for too long.
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(3))
			// Below the rise low level, and above the rise high level.
			0: return SAMPLE_W'($urandom_range(337));
			1: return SAMPLE_W'($urandom_range(1023, 389));
			2: begin
				// Values around zero millivolts, full scale and the rise thresholds.
				case ($urandom_range(5))
					0: return '0;
					1: return '1;
					2: return SAMPLE_W'(22);
					3: return SAMPLE_W'(337);
					4: return SAMPLE_W'(388);
					default: return SAMPLE_W'(389);
				endcase
			end
			default: return SAMPLE_W'($urandom_range(1023));
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] any_command();
		return CMD_W'($urandom_range(3));
	endfunction

	task automatic set_idling(input int kind);
		case (kind)
			0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
			1: begin tx_idle_pct = 79; rx_stall_pct = 0; end
			2: begin tx_idle_pct = 0; rx_stall_pct = 79; end
			default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
		endcase
	endtask

	// Offers one event word and notes it once the block takes it.
	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.sample <= smp;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_event(cmd, smp);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.set_reg(idx, data);
	endtask

	task automatic load_settings(input int meas, input int load, input int high, input int low);
		write_reg(REG_MEASURE_INTERVAL, CFG_DATA_W'(meas));
		write_reg(REG_LOAD_INTERVAL, CFG_DATA_W'(load));
		write_reg(REG_PRECHECK_HIGH, CFG_DATA_W'(high));
		write_reg(REG_PRECHECK_LOW, CFG_DATA_W'(low));
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every expected result word has been taken, then lets the block settle.
	task automatic drain_pipeline();
		in_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Precheck traffic: mostly tick and conversion pairs, some restarts and noise.
	task automatic run_precheck(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 10) send_event(any_command(), SAMPLE_W'($urandom_range(1023)));
			else if (pick < 15) send_event(CMD_INIT, SAMPLE_W'($urandom_range(1023)));
			else if (pick < 20) send_event(CMD_UNPARK, SAMPLE_W'($urandom_range(1023)));
			else if (sb.pre_wait) send_event(CMD_DONE, pick_sample());
			else send_event(CMD_TICK, SAMPLE_W'($urandom_range(1023)));
		end
	endtask

	// Feeds identical samples until three in a row end the precheck.
	task automatic finish_precheck();
		logic [SAMPLE_W-1:0] level;
		level = $urandom_range(1) ? '1 : '0;
		while (sb.pre_flag) begin
			if (sb.pre_mode == PRE_PARKED) send_event(CMD_UNPARK, level);
			else if (sb.pre_wait) send_event(CMD_DONE, level);
			else send_event(CMD_TICK, level);
		end
	endtask

	// Scheduler traffic: complete measurements with random samples, plus noise.
	task automatic run_schedule(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 8) send_event(any_command(), SAMPLE_W'($urandom_range(1023)));
			else if (pick < 10) send_event(CMD_INIT, SAMPLE_W'($urandom_range(1023)));
			else if (sb.phase != PH_IDLE) send_event(CMD_DONE, pick_sample());
			else if (sb.mode == MODE_PARKED) send_event(CMD_UNPARK, SAMPLE_W'($urandom_range(1023)));
			else send_event(CMD_TICK, SAMPLE_W'($urandom_range(1023)));
		end
	endtask

	initial begin : main
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_requests = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.command <= CMD_INIT;
		in_ch.sample <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_MEASURE_INTERVAL;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Precheck with reset settings: events before init, a restart, no early exit.
		send_event(CMD_DONE, '1);
		send_event(CMD_TICK, '0);
		send_event(CMD_UNPARK, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_DONE, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_DONE, '1);
		send_event(CMD_TICK, '0);
		send_event(CMD_DONE, '0);
		send_event(CMD_INIT, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_DONE, '1);

		// Thresholds at the extremes keep the precheck running under random traffic.
		drain_pipeline();
		load_settings($urandom_range(255), $urandom_range(255), MV_MAX, 0);
		set_idling(3);
		run_precheck(150);

		drain_pipeline();
		load_settings($urandom_range(255), $urandom_range(255),
			$urandom_range(7920, 1000), $urandom_range(3000, 1));
		set_idling(0);
		finish_precheck();

		// Scheduler: loaded measurement, then a rise into the pulse pattern.
		drain_pipeline();
		load_settings(1, 0, $urandom_range(MV_MAX), $urandom_range(MV_MAX));
		send_event(CMD_INIT, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_DONE, SAMPLE_W'(300));
		send_event(CMD_DONE, SAMPLE_W'(300));
		send_event(CMD_UNPARK, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_DONE, '1);
		send_event(CMD_DONE, '1);
		send_event(CMD_TICK, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_UNPARK, '0);
		send_event(CMD_DONE, SAMPLE_W'(512));

		// Random phases over several interval settings and idling patterns.
		for (int p = 0; p < 8; p++) begin
			drain_pipeline();
			case (p)
				0: load_settings(1, 0, $urandom_range(MV_MAX), $urandom_range(MV_MAX));
				1: load_settings(255, 0, $urandom_range(MV_MAX), $urandom_range(MV_MAX));
				2: load_settings(2, 1, $urandom_range(MV_MAX), $urandom_range(MV_MAX));
				3: load_settings(0, $urandom_range(255), $urandom_range(MV_MAX), 0);
				4: load_settings(1, 255, MV_MAX, $urandom_range(MV_MAX));
				5: load_settings(3, 0, $urandom_range(MV_MAX), $urandom_range(MV_MAX));
				default: load_settings($urandom_range(6, 1), $urandom_range(2),
					$urandom_range(MV_MAX), $urandom_range(MV_MAX));
			endcase
			set_idling(p % 4);
			// Long result hold-off while the sender keeps offering words.
			if (p == 4) hold_requests++;
			if (p == 1) run_schedule(400);
			else if (p == 3) run_schedule(60);
			else run_schedule(140);
		end

		drain_pipeline();
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
src/bms_pkg.sv
src/bms_if.sv
src/bms_core.sv
src/battery_measure_sequencer.sv
tb/tb_top.sv
